/* rtl/stable_priority_queue_defines.svh */
// Assertion macros for the stable priority queue checker.
// No dependencies; included by the checker file only.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication that is also checked across reset.
`define SPQ_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Shared types and constants of the stable priority queue.
// No dependencies; used by every module of the block.
package spq_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int PRIO_BITS = 4;
  localparam int TAG_BITS  = 16;
  localparam int OCC_BITS  = 8;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [PRIO_BITS-1:0] entry_priority;
    logic [TAG_BITS-1:0]  entry_tag;
  } in_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PRIO_BITS-1:0] head_priority;
    logic [TAG_BITS-1:0]  head_tag;
    logic [OCC_BITS-1:0]  occupancy;
  } out_rsp_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_HEAD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic push_init;
    logic shift;
    logic place;
    logic head_read;
    logic head_rsp;
    logic trivial_rsp;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic in_push;
    logic in_head;
    logic full;
    logic empty;
    logic stop;
  } dp_sts_t;

endpackage

/* rtl/stable_priority_queue.sv */
// Top level of the stable priority queue: sequencer plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//   channel  ports                        handshake
//   request  in_req (cmd, prio, tag)      taken when start & !busy
//   result   out_rsp (status, head, occ)  out_valid strobe, one cycle
//
// Refused and unused commands answer straight from idle; pop and peek go through
// the head read; a push moves k entries down the queue (k up to the fill count).
// The push walks the entry memory, which has one read and one write port,
// one slot per cycle from the tail toward the head.
// busy drops in the cycle the strobe shows, so the next request can be taken
// then. No clearing pass after reset: the fill count guards every read.
// Results cannot be stalled; reset clears the pointers, the count and the strobe.
module stable_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::in_req_t  in_req,
  output logic              out_valid,
  output spq_pkg::out_rsp_t out_rsp
);

  spq_pkg::dp_ctl_t ctl;
  spq_pkg::dp_sts_t sts;

  // Sequencer: idle -> shift loop (push) or head read (pop/peek) -> idle.
  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Entry memory, head/tail pointers, fill count and the result register.
  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

/* rtl/spq_ctrl.sv */
// Sequencer of the stable priority queue.
// Depends on spq_pkg; drives spq_datapath through dp_ctl_t.
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  spq_pkg::dp_sts_t sts,
  output spq_pkg::dp_ctl_t ctl,
  output logic             busy
);

  spq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (start) begin
          if (sts.in_push && !sts.full) begin
            state_nxt = spq_pkg::S_SHIFT;
          end else if (sts.in_head && !sts.empty) begin
            state_nxt = spq_pkg::S_HEAD;
          end
        end
      end
      spq_pkg::S_SHIFT: begin
        if (sts.stop) begin
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      spq_pkg::S_HEAD: begin
        state_nxt = spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state_r)
      spq_pkg::S_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
        if (start) begin
          if (sts.in_push && !sts.full) begin
            ctl.push_init = 1'b1;
          end else if (sts.in_head && !sts.empty) begin
            ctl.head_read = 1'b1;
          end else begin
            ctl.trivial_rsp = 1'b1;
          end
        end
      end
      spq_pkg::S_SHIFT: begin
        ctl.place = sts.stop;
        ctl.shift = !sts.stop;
      end
      spq_pkg::S_HEAD: begin
        ctl.head_rsp = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/spq_datapath.sv */
// Storage, pointers and result register of the stable priority queue.
// Depends on spq_pkg; commanded by spq_ctrl.
module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::in_req_t  in_req,
  input  spq_pkg::dp_ctl_t  ctl,
  output spq_pkg::dp_sts_t  sts,
  output logic              out_valid,
  output spq_pkg::out_rsp_t out_rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // circular buffer, sorted from head_r (most urgent) to tail_r
  spq_pkg::entry_t mem [DEPTH];
  spq_pkg::entry_t rd_data_r;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r;    // hole being filled
  logic [IDX_W-1:0] rp_r;     // slot whose data sits in rd_data_r
  logic [CNT_W-1:0] steps_r;  // entries still ahead of the hole
  logic [spq_pkg::PRIO_BITS-1:0] prio_r;
  logic [spq_pkg::TAG_BITS-1:0]  tag_r;
  logic                          pop_r;

  logic              out_valid_r;
  spq_pkg::out_rsp_t out_rsp_r;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  spq_pkg::entry_t  wr_data;

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] x);
    idx_prev = (x == '0) ? LAST_IDX : x - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] x);
    idx_next = (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  assign sts.in_push = (in_req.cmd == spq_pkg::CMD_PUSH);
  assign sts.in_head = (in_req.cmd == spq_pkg::CMD_POP) || (in_req.cmd == spq_pkg::CMD_PEEK);
  assign sts.full    = (count_r == FULL_CNT);
  assign sts.empty   = (count_r == '0);
  assign sts.stop    = (steps_r == '0) || (rd_data_r.prio <= prio_r);

  always_comb begin
    rd_addr = head_r;
    if (ctl.push_init) begin
      rd_addr = idx_prev(tail_r);
    end else if (ctl.shift) begin
      rd_addr = idx_prev(rp_r);
    end
  end

  assign wr_en = ctl.shift || ctl.place;

  always_comb begin
    wr_data = rd_data_r;
    if (ctl.place) begin
      wr_data.prio = prio_r;
      wr_data.tag  = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    if (ctl.head_read || ctl.push_init || ctl.shift) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.place) begin
      tail_nxt  = idx_next(tail_r);
      count_nxt = count_r + 1'b1;
    end else if (ctl.head_rsp && pop_r) begin
      head_nxt  = idx_next(head_r);
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= ctl.place || ctl.head_rsp || ctl.trivial_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      prio_r <= in_req.entry_priority;
      tag_r  <= in_req.entry_tag;
      pop_r  <= (in_req.cmd == spq_pkg::CMD_POP);
    end
    if (ctl.push_init) begin
      pos_r   <= tail_r;
      rp_r    <= idx_prev(tail_r);
      steps_r <= count_r;
    end else if (ctl.shift) begin
      pos_r   <= rp_r;
      rp_r    <= idx_prev(rp_r);
      steps_r <= steps_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.place) begin
      out_rsp_r.status        <= spq_pkg::STAT_OK;
      out_rsp_r.head_priority <= '0;
      out_rsp_r.head_tag      <= '0;
      out_rsp_r.occupancy     <= spq_pkg::OCC_BITS'(count_nxt);
    end else if (ctl.head_rsp) begin
      out_rsp_r.status        <= spq_pkg::STAT_OK;
      out_rsp_r.head_priority <= rd_data_r.prio;
      out_rsp_r.head_tag      <= rd_data_r.tag;
      out_rsp_r.occupancy     <= spq_pkg::OCC_BITS'(count_nxt);
    end else if (ctl.trivial_rsp) begin
      if (sts.in_push) begin
        out_rsp_r.status <= spq_pkg::STAT_FULL;
      end else if (sts.in_head) begin
        out_rsp_r.status <= spq_pkg::STAT_EMPTY;
      end else begin
        out_rsp_r.status <= spq_pkg::STAT_OK;
      end
      out_rsp_r.head_priority <= '0;
      out_rsp_r.head_tag      <= '0;
      out_rsp_r.occupancy     <= spq_pkg::OCC_BITS'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

/* rtl/spq_checker.sv */
// Port-level checks of the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_defines.svh.
`include "stable_priority_queue_defines.svh"

module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input spq_pkg::in_req_t  in_req,
  input logic              out_valid,
  input spq_pkg::out_rsp_t out_rsp
);

  localparam logic [spq_pkg::OCC_BITS-1:0] FULL_OCC = spq_pkg::OCC_BITS'(DEPTH);

  `SPQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n, !out_valid && !busy, "strobe or busy after reset")
  `SPQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "request dropped")
  `SPQ_ASSERT_NOW(a_strobe_frees, out_valid, !busy, "busy while result shown")
  `SPQ_ASSERT_NOW(a_refused_zero, out_valid && (out_rsp.status != spq_pkg::STAT_OK), (out_rsp.head_priority == '0) && (out_rsp.head_tag == '0), "head fields on refusal")
  `SPQ_ASSERT_NOW(a_full_occ, out_valid && (out_rsp.status == spq_pkg::STAT_FULL), out_rsp.occupancy == FULL_OCC, "full status below depth")

endmodule

bind stable_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
